>>> rtl/lcdws_pkg.sv
// ----------------------------------------------------------------------------
// lcdws_pkg
// Shared types and constants for the character LCD write sequencer: command
// codes, control port bits, register indexes, state encodings and the
// structures passed between the sequencer modules.
// ----------------------------------------------------------------------------
package lcdws_pkg;

   // Depth of the string buffer.
   localparam int BUFFER_LENGTH_DEF = 16;

   // Request actions. Any other code behaves as a tick.
   localparam logic [1:0] ACT_SEND = 2'd1;
   localparam logic [1:0] ACT_LOAD = 2'd2;

   // Register indexes on the configuration port.
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_STROBE_DELAY  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_MODE   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_PERIOD = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCROLL_LENGTH = 4'd3;

   // Register reset values.
   localparam logic [7:0] STROBE_DELAY_RST  = 8'd3;
   localparam logic [1:0] SCROLL_MODE_RST   = 2'd0;
   localparam logic [7:0] SCROLL_PERIOD_RST = 8'd1;
   localparam logic [7:0] SCROLL_LENGTH_RST = 8'd0;

   // Scroll modes. Mode three acts as scroll left.
   localparam logic [1:0] SCROLL_OFF   = 2'd0;
   localparam logic [1:0] SCROLL_RIGHT = 2'd2;

   // Display command codes.
   localparam logic [7:0] CMD_HOME        = 8'h02;
   localparam logic [7:0] CMD_SHIFT_RIGHT = 8'h1C;
   localparam logic [7:0] CMD_SHIFT_LEFT  = 8'h18;

   // Control port bits.
   localparam logic [7:0] CTL_RS   = 8'h80;
   localparam logic [7:0] CTL_E    = 8'h40;
   localparam logic [7:0] CTL_NONE = 8'h00;

   // Port select on the result.
   localparam logic PORT_CONTROL = 1'b0;
   localparam logic PORT_DATA    = 1'b1;

   // Byte writer phases.
   typedef enum logic [5:0] {
      WR_IDLE  = 6'b000001,
      WR_START = 6'b000010,
      WR_TYPE  = 6'b000100,
      WR_DATA  = 6'b001000,
      WR_E1    = 6'b010000,
      WR_E0    = 6'b100000
   } wr_phase_type;

   // String sender phases.
   typedef enum logic [2:0] {
      STR_IDLE  = 3'b001,
      STR_START = 3'b010,
      STR_WAIT  = 3'b100
   } str_phase_type;

   // Current register settings.
   typedef struct packed {
      logic [7:0] strobe_delay;
      logic [1:0] scroll_mode;
      logic [7:0] scroll_period;
      logic [7:0] scroll_length;
   } cfg_type;

   // Reload of the scroll timer and counter on a register write.
   typedef struct packed {
      logic       load_timer;
      logic       load_count;
      logic [7:0] value;
   } cfg_load_type;

   // One result of the sequencer.
   typedef struct packed {
      logic       write_valid;
      logic       write_port;
      logic [7:0] write_value;
      logic       command_done;
      logic       busy_res;
      logic       accepted;
   } rsp_type;

endpackage

>>> rtl/char_lcd_write_sequencer.sv
// Results enter the two-entry result queue as requests are accepted. Throughput: one
// request per cycle while the queue is not full; the queue keeps requests flowing
// while a result waits, and the string buffer is read ahead for the next request.
// Reset is synchronous and clears all control state and the registers; the string
// buffer is not cleared and holds nothing valid until loaded.
// ----------------------------------------------------------------------------
// char_lcd_write_sequencer
// Top level: writes bytes to a character LCD as four port writes, sends a
// buffered string and scrolls the display on a tick.
// ----------------------------------------------------------------------------
module char_lcd_write_sequencer
   import lcdws_pkg::*;
#(
   parameter int BUFFER_LENGTH = BUFFER_LENGTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic                 req_is_data,
   input  logic [7:0]           req_byte_value,
   input  logic                 req_last_char,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_write_valid,
   output logic                 rsp_write_port,
   output logic [7:0]           rsp_write_value,
   output logic                 rsp_command_done,
   output logic                 rsp_busy_res,
   output logic                 rsp_accepted,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_wdata
);

   localparam int IDX_W  = $clog2(BUFFER_LENGTH + 1);
   localparam int ADDR_W = (BUFFER_LENGTH > 1) ? $clog2(BUFFER_LENGTH) : 1;

   cfg_type      cfg_ff, cfg_in;
   cfg_load_type cfg_load;
   logic         csr_write;
   logic         req_accept;
   logic         queue_full;
   logic         mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]   mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [7:0]   mem_rd_data;
   rsp_type      core_result;
   rsp_type      rsp_data;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign req_ready  = !queue_full;
   assign req_accept = req_valid && req_ready;

   // Register writes; unknown indexes are ignored.
   always_comb begin
      cfg_in              = cfg_ff;
      cfg_load.load_timer = 1'b0;
      cfg_load.load_count = 1'b0;
      cfg_load.value      = csr_wdata;
      if (csr_write) begin
         case (csr_index)
            CSR_STROBE_DELAY: begin
               cfg_in.strobe_delay = csr_wdata;
            end
            CSR_SCROLL_MODE: begin
               cfg_in.scroll_mode = csr_wdata[1:0];
            end
            CSR_SCROLL_PERIOD: begin
               cfg_in.scroll_period = csr_wdata;
               cfg_load.load_timer  = 1'b1;
            end
            CSR_SCROLL_LENGTH: begin
               cfg_in.scroll_length = csr_wdata;
               cfg_load.load_count  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strobe_delay  <= STROBE_DELAY_RST;
         cfg_ff.scroll_mode   <= SCROLL_MODE_RST;
         cfg_ff.scroll_period <= SCROLL_PERIOD_RST;
         cfg_ff.scroll_length <= SCROLL_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // String buffer.
   lcdws_str_mem #(
      .DEPTH  (BUFFER_LENGTH),
      .ADDR_W (ADDR_W)
   ) u_str_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sequencer state and update.
   lcdws_core #(
      .BUFFER_LENGTH (BUFFER_LENGTH),
      .IDX_W         (IDX_W),
      .ADDR_W        (ADDR_W)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .item_accept     (req_accept),
      .item_action     (req_action),
      .item_is_data    (req_is_data),
      .item_byte_value (req_byte_value),
      .item_last_char  (req_last_char),
      .cfg             (cfg_ff),
      .cfg_load        (cfg_load),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .result          (core_result)
   );

   // Result queue.
   lcdws_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (core_result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_write_valid  = rsp_data.write_valid;
   assign rsp_write_port   = rsp_data.write_port;
   assign rsp_write_value  = rsp_data.write_value;
   assign rsp_command_done = rsp_data.command_done;
   assign rsp_busy_res     = rsp_data.busy_res;
   assign rsp_accepted     = rsp_data.accepted;

endmodule

>>> rtl/lcdws_str_mem.sv
// ----------------------------------------------------------------------------
// lcdws_str_mem
// String buffer: one write port and one registered read port. A write and a
// read of the same entry in one cycle return the new data.
// ----------------------------------------------------------------------------
module lcdws_str_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Storage write; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read with write-through forwarding.
   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lcdws_core.sv
// ----------------------------------------------------------------------------
// lcdws_core
// Sequencer state and per-request update: byte writer, string sender and
// scroller. String characters are read from the buffer memory, whose read
// address follows the next read index so the data is ready for the next
// request.
// ----------------------------------------------------------------------------
module lcdws_core
   import lcdws_pkg::*;
#(
   parameter int BUFFER_LENGTH = BUFFER_LENGTH_DEF,
   parameter int IDX_W         = 5,
   parameter int ADDR_W        = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_accept,
   input  logic [1:0]        item_action,
   input  logic              item_is_data,
   input  logic [7:0]        item_byte_value,
   input  logic              item_last_char,
   input  cfg_type           cfg,
   input  cfg_load_type      cfg_load,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [7:0]        mem_wr_data,
   output logic [ADDR_W-1:0] mem_rd_addr,
   input  logic [7:0]        mem_rd_data,
   output rsp_type           result
);

   wr_phase_type  writer_phase_ff, writer_phase_in;
   logic [7:0]    phase_delay_ff, phase_delay_in;
   logic          pending_is_data_ff, pending_is_data_in;
   logic [7:0]    pending_byte_ff, pending_byte_in;
   str_phase_type string_phase_ff, string_phase_in;
   logic [IDX_W-1:0] read_idx_ff, read_idx_in;
   logic [IDX_W-1:0] load_idx_ff, load_idx_in;
   logic [IDX_W-1:0] length_ff, length_in;
   logic [7:0]    scroll_timer_ff, scroll_timer_in;
   logic [7:0]    scroll_count_ff, scroll_count_in;

   logic [7:0]    rs_bits;
   logic [7:0]    delay_dec;
   logic [7:0]    timer_dec;

   // State update for one request.
   always_comb begin
      writer_phase_in    = writer_phase_ff;
      phase_delay_in     = phase_delay_ff;
      pending_is_data_in = pending_is_data_ff;
      pending_byte_in    = pending_byte_ff;
      string_phase_in    = string_phase_ff;
      read_idx_in        = read_idx_ff;
      load_idx_in        = load_idx_ff;
      length_in          = length_ff;
      scroll_timer_in    = scroll_timer_ff;
      scroll_count_in    = scroll_count_ff;
      result             = '0;
      mem_wr_en          = 1'b0;
      mem_wr_addr        = load_idx_ff[ADDR_W-1:0];
      mem_wr_data        = item_byte_value;
      rs_bits            = pending_is_data_ff ? CTL_RS : CTL_NONE;
      delay_dec          = phase_delay_ff - 8'd1;
      timer_dec          = scroll_timer_ff - 8'd1;

      if (item_accept) begin
         case (item_action)
            ACT_SEND: begin
               if (writer_phase_ff == WR_IDLE) begin
                  pending_is_data_in = item_is_data;
                  pending_byte_in    = item_byte_value;
                  writer_phase_in    = WR_START;
                  result.accepted    = 1'b1;
               end
            end
            ACT_LOAD: begin
               if (load_idx_ff < IDX_W'(BUFFER_LENGTH)) begin
                  mem_wr_en       = 1'b1;
                  load_idx_in     = load_idx_ff + IDX_W'(1);
                  result.accepted = 1'b1;
               end
               // The final character starts output from the first entry.
               if (item_last_char) begin
                  length_in       = load_idx_in;
                  load_idx_in     = '0;
                  read_idx_in     = '0;
                  string_phase_in = STR_START;
               end
            end
            default: begin
               // Byte writer: four port writes, each followed by a wait.
               case (writer_phase_ff)
                  WR_IDLE: begin
                  end
                  WR_START: begin
                     result.write_valid = 1'b1;
                     result.write_port  = PORT_CONTROL;
                     result.write_value = rs_bits;
                     phase_delay_in     = cfg.strobe_delay;
                     writer_phase_in    = WR_TYPE;
                  end
                  WR_TYPE: begin
                     phase_delay_in = delay_dec;
                     if (delay_dec == 8'd0) begin
                        result.write_valid = 1'b1;
                        result.write_port  = PORT_DATA;
                        result.write_value = pending_byte_ff;
                        phase_delay_in     = cfg.strobe_delay;
                        writer_phase_in    = WR_DATA;
                     end
                  end
                  WR_DATA: begin
                     phase_delay_in = delay_dec;
                     if (delay_dec == 8'd0) begin
                        result.write_valid = 1'b1;
                        result.write_port  = PORT_CONTROL;
                        result.write_value = rs_bits | CTL_E;
                        phase_delay_in     = cfg.strobe_delay;
                        writer_phase_in    = WR_E1;
                     end
                  end
                  WR_E1: begin
                     phase_delay_in = delay_dec;
                     if (delay_dec == 8'd0) begin
                        result.write_valid = 1'b1;
                        result.write_port  = PORT_CONTROL;
                        result.write_value = CTL_NONE;
                        phase_delay_in     = cfg.strobe_delay;
                        writer_phase_in    = WR_E0;
                     end
                  end
                  WR_E0: begin
                     phase_delay_in = delay_dec;
                     if (delay_dec == 8'd0) begin
                        writer_phase_in     = WR_IDLE;
                        result.command_done = 1'b1;
                     end
                  end
                  default: begin
                     writer_phase_in = WR_IDLE;
                  end
               endcase

               // String sender: hand the next character to an idle writer.
               case (string_phase_ff)
                  STR_START: begin
                     if ((read_idx_ff >= length_ff) ||
                         (read_idx_ff >= IDX_W'(BUFFER_LENGTH)) ||
                         (mem_rd_data == 8'd0)) begin
                        string_phase_in = STR_IDLE;
                     end else if (writer_phase_in == WR_IDLE) begin
                        pending_is_data_in = 1'b1;
                        pending_byte_in    = mem_rd_data;
                        writer_phase_in    = WR_START;
                        read_idx_in        = read_idx_ff + IDX_W'(1);
                        string_phase_in    = STR_WAIT;
                     end
                  end
                  STR_WAIT: begin
                     if (writer_phase_in == WR_IDLE) begin
                        string_phase_in = STR_START;
                     end
                  end
                  default: begin
                     string_phase_in = STR_IDLE;
                  end
               endcase

               // Scroller: count idle ticks, then shift or return home.
               if ((cfg.scroll_mode != SCROLL_OFF) && (writer_phase_in == WR_IDLE)) begin
                  scroll_timer_in = timer_dec;
                  if (timer_dec == 8'd0) begin
                     pending_is_data_in = 1'b0;
                     writer_phase_in    = WR_START;
                     if (scroll_count_ff == 8'd0) begin
                        scroll_count_in = cfg.scroll_length;
                        pending_byte_in = CMD_HOME;
                     end else begin
                        scroll_count_in = scroll_count_ff - 8'd1;
                        pending_byte_in = (cfg.scroll_mode == SCROLL_RIGHT) ?
                                          CMD_SHIFT_RIGHT : CMD_SHIFT_LEFT;
                     end
                     scroll_timer_in = cfg.scroll_period;
                  end
               end
            end
         endcase
      end

      // Register writes reload the scroll timer and counter.
      if (cfg_load.load_timer) begin
         scroll_timer_in = cfg_load.value;
      end
      if (cfg_load.load_count) begin
         scroll_count_in = cfg_load.value;
      end

      result.busy_res = (writer_phase_in != WR_IDLE);
   end

   // The buffer read follows the next read index.
   assign mem_rd_addr = read_idx_in[ADDR_W-1:0];

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         writer_phase_ff    <= WR_IDLE;
         phase_delay_ff     <= '0;
         pending_is_data_ff <= 1'b0;
         pending_byte_ff    <= '0;
         string_phase_ff    <= STR_IDLE;
         read_idx_ff        <= '0;
         load_idx_ff        <= '0;
         length_ff          <= '0;
         scroll_timer_ff    <= 8'd1;
         scroll_count_ff    <= '0;
      end else begin
         writer_phase_ff    <= writer_phase_in;
         phase_delay_ff     <= phase_delay_in;
         pending_is_data_ff <= pending_is_data_in;
         pending_byte_ff    <= pending_byte_in;
         string_phase_ff    <= string_phase_in;
         read_idx_ff        <= read_idx_in;
         load_idx_ff        <= load_idx_in;
         length_ff          <= length_in;
         scroll_timer_ff    <= scroll_timer_in;
         scroll_count_ff    <= scroll_count_in;
      end
   end

endmodule

>>> rtl/lcdws_rsp_queue.sv
// ----------------------------------------------------------------------------
// lcdws_rsp_queue
// Two-entry result queue between the sequencer and the result channel, so a
// new request is taken while an earlier result still waits.
// ----------------------------------------------------------------------------
module lcdws_rsp_queue
   import lcdws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   rsp_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = (count_ff == 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
